@@ design/sb2d_pkg.sv @@
// Shared types and constants for the signed binary to decimal ASCII core.
// Used by sb2d_dabble, sb2d_emit and signed_binary_to_decimal_ascii_core.
// No dependencies.
package sb2d_pkg;

    // Field widths.
    localparam int VALUE_W   = 64;
    localparam int CHAR_W    = 6;
    localparam int DIGIT_W   = 4;
    localparam int NUM_DIGITS = 20;
    localparam int BCD_W     = NUM_DIGITS * DIGIT_W;

    // Shift counter for the binary to BCD conversion.
    localparam int CNT_W = $clog2(VALUE_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(VALUE_W - 1);

    // Digit countdown in the emitter.
    localparam int REM_W = $clog2(NUM_DIGITS + 1);
    localparam logic [REM_W-1:0] REM_FULL = REM_W'(NUM_DIGITS);
    localparam logic [REM_W-1:0] REM_ONE  = REM_W'(1);

    // ASCII codes, kept to the six bits of the character field.
    localparam logic [CHAR_W-1:0] CHAR_MINUS = CHAR_W'(45);
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = CHAR_W'(48);

    // Double-dabble correction threshold and offset.
    localparam logic [DIGIT_W-1:0] DABBLE_LIMIT = DIGIT_W'(5);
    localparam logic [DIGIT_W-1:0] DABBLE_ADD   = DIGIT_W'(3);

    typedef enum logic [1:0] {
        CONV_IDLE,
        CONV_SHIFT,
        CONV_DONE
    } t_conv_state;

    typedef enum logic [1:0] {
        EMIT_IDLE,
        EMIT_SIGN,
        EMIT_DIGITS
    } t_emit_state;

    // Result handed from the converter to the emitter.
    typedef struct packed {
        logic             neg;
        logic [BCD_W-1:0] bcd;
    } t_conv_result;

endpackage

@@ design/sb2d_dabble.sv @@
// Bit-serial binary to BCD converter (shift-and-add-3), one bit per cycle.
// Depends on sb2d_pkg for widths, state type and the result struct.
module sb2d_dabble (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic signed [sb2d_pkg::VALUE_W-1:0] i_value,
    output logic                             o_valid,
    input  logic                             i_ready,
    output sb2d_pkg::t_conv_result           o_result
);

    sb2d_pkg::t_conv_state r_state, n_state;
    logic [sb2d_pkg::VALUE_W-1:0] r_bin, n_bin;
    logic [sb2d_pkg::BCD_W-1:0]   r_bcd, n_bcd;
    logic [sb2d_pkg::CNT_W-1:0]   r_cnt, n_cnt;
    logic                         r_neg, n_neg;
    logic [sb2d_pkg::BCD_W-1:0]   w_adj;

    // Add three to every digit of five or more before the shift.
    always_comb begin
        logic [sb2d_pkg::DIGIT_W-1:0] digit;
        for (int i = 0; i < sb2d_pkg::NUM_DIGITS; i++) begin
            digit = r_bcd[i*sb2d_pkg::DIGIT_W +: sb2d_pkg::DIGIT_W];
            if (digit >= sb2d_pkg::DABBLE_LIMIT) begin
                w_adj[i*sb2d_pkg::DIGIT_W +: sb2d_pkg::DIGIT_W] = digit + sb2d_pkg::DABBLE_ADD;
            end else begin
                w_adj[i*sb2d_pkg::DIGIT_W +: sb2d_pkg::DIGIT_W] = digit;
            end
        end
    end

    // Next state: load the magnitude, shift it through, then hold the result.
    always_comb begin
        n_state = r_state;
        n_bin   = r_bin;
        n_bcd   = r_bcd;
        n_cnt   = r_cnt;
        n_neg   = r_neg;
        case (r_state)
            sb2d_pkg::CONV_IDLE: begin
                if (i_valid) begin
                    n_neg   = i_value[sb2d_pkg::VALUE_W-1];
                    // Unsigned negation also covers the most negative value.
                    n_bin   = i_value[sb2d_pkg::VALUE_W-1] ? (~i_value) + 1'b1 : i_value;
                    n_bcd   = '0;
                    n_cnt   = '0;
                    n_state = sb2d_pkg::CONV_SHIFT;
                end
            end
            sb2d_pkg::CONV_SHIFT: begin
                n_bcd = {w_adj[sb2d_pkg::BCD_W-2:0], r_bin[sb2d_pkg::VALUE_W-1]};
                n_bin = {r_bin[sb2d_pkg::VALUE_W-2:0], 1'b0};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == sb2d_pkg::CNT_LAST) begin
                    n_state = sb2d_pkg::CONV_DONE;
                end
            end
            sb2d_pkg::CONV_DONE: begin
                if (i_ready) begin
                    n_state = sb2d_pkg::CONV_IDLE;
                end
            end
            default: begin
                n_state = sb2d_pkg::CONV_IDLE;
            end
        endcase
    end

    // State register; the data path needs no reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sb2d_pkg::CONV_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_bin <= n_bin;
        r_bcd <= n_bcd;
        r_cnt <= n_cnt;
        r_neg <= n_neg;
    end

    assign o_ready      = (r_state == sb2d_pkg::CONV_IDLE);
    assign o_valid      = (r_state == sb2d_pkg::CONV_DONE);
    assign o_result.neg = r_neg;
    assign o_result.bcd = r_bcd;

endmodule

@@ design/sb2d_emit.sv @@
// Character serializer: emits the sign and the BCD digits as ASCII, at most one per cycle
// and none while the output stalls, skipping leading zeros. Depends on sb2d_pkg.
module sb2d_emit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  sb2d_pkg::t_conv_result          i_result,
    output logic                            o_tvalid,
    input  logic                            i_tready,
    output logic [sb2d_pkg::CHAR_W-1:0]     o_char,
    output logic                            o_last
);

    sb2d_pkg::t_emit_state r_state, n_state;
    logic [sb2d_pkg::BCD_W-1:0]  r_bcd, n_bcd;
    logic [sb2d_pkg::REM_W-1:0]  r_rem, n_rem;
    logic                        r_lead, n_lead;
    logic                        r_tvalid, n_tvalid;
    logic [sb2d_pkg::CHAR_W-1:0] r_char, n_char;
    logic                        r_last, n_last;
    logic                        w_free;
    logic [sb2d_pkg::DIGIT_W-1:0] w_top;

    // The output register can take a new character when empty or being drained.
    assign w_free = !r_tvalid || i_tready;
    assign w_top  = r_bcd[sb2d_pkg::BCD_W-1 -: sb2d_pkg::DIGIT_W];

    always_comb begin
        n_state  = r_state;
        n_bcd    = r_bcd;
        n_rem    = r_rem;
        n_lead   = r_lead;
        n_tvalid = r_tvalid && !i_tready;
        n_char   = r_char;
        n_last   = r_last;
        case (r_state)
            sb2d_pkg::EMIT_IDLE: begin
                if (i_valid) begin
                    n_bcd   = i_result.bcd;
                    n_rem   = sb2d_pkg::REM_FULL;
                    n_lead  = 1'b1;
                    n_state = i_result.neg ? sb2d_pkg::EMIT_SIGN : sb2d_pkg::EMIT_DIGITS;
                end
            end
            sb2d_pkg::EMIT_SIGN: begin
                if (w_free) begin
                    n_tvalid = 1'b1;
                    n_char   = sb2d_pkg::CHAR_MINUS;
                    n_last   = 1'b0;
                    n_state  = sb2d_pkg::EMIT_DIGITS;
                end
            end
            sb2d_pkg::EMIT_DIGITS: begin
                if (r_lead && (w_top == '0) && (r_rem != sb2d_pkg::REM_ONE)) begin
                    // Drop a leading zero; the units digit is always sent.
                    n_bcd = {r_bcd[sb2d_pkg::BCD_W-sb2d_pkg::DIGIT_W-1:0],
                             {sb2d_pkg::DIGIT_W{1'b0}}};
                    n_rem = r_rem - 1'b1;
                end else if (w_free) begin
                    n_tvalid = 1'b1;
                    n_char   = sb2d_pkg::CHAR_ZERO + {{(sb2d_pkg::CHAR_W-sb2d_pkg::DIGIT_W){1'b0}},
                                                      w_top};
                    n_last   = (r_rem == sb2d_pkg::REM_ONE);
                    n_lead   = 1'b0;
                    n_bcd    = {r_bcd[sb2d_pkg::BCD_W-sb2d_pkg::DIGIT_W-1:0],
                                {sb2d_pkg::DIGIT_W{1'b0}}};
                    n_rem    = r_rem - 1'b1;
                    if (r_rem == sb2d_pkg::REM_ONE) begin
                        n_state = sb2d_pkg::EMIT_IDLE;
                    end
                end
            end
            default: begin
                n_state = sb2d_pkg::EMIT_IDLE;
            end
        endcase
    end

    // Only the state and the output valid are reset; digits, characters and counters are not.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= sb2d_pkg::EMIT_IDLE;
            r_tvalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_tvalid <= n_tvalid;
        end
        r_bcd  <= n_bcd;
        r_rem  <= n_rem;
        r_lead <= n_lead;
        r_char <= n_char;
        r_last <= n_last;
    end

    assign o_ready  = (r_state == sb2d_pkg::EMIT_IDLE);
    assign o_tvalid = r_tvalid;
    assign o_char   = r_char;
    assign o_last   = r_last;

endmodule

@@ design/signed_binary_to_decimal_ascii_core.sv @@
// Signed 64-bit integer to decimal ASCII text, one character per output transfer.
// Flow: the bit-serial BCD converter shifts in the magnitude one bit per cycle, then
// hands the result on; the emitter skips leading zeros, then sends 1 to 20 characters,
// one per cycle unless the output stalls. The emitter drains the previous item while
// the converter works on the next, so a new value can be taken before the last is sent.
// Reset: synchronous, active low; clears the control state, no clearing pass.
module signed_binary_to_decimal_ascii_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // tdata: [63:0] value
    input  logic signed [sb2d_pkg::VALUE_W-1:0]  i_s_axis_tdata,
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    // tdata: [5:0] character, [7:6] zero
    output logic [7:0]                           o_m_axis_tdata,
    output logic                                 o_m_axis_tlast
);

    logic                        w_conv_valid;
    logic                        w_conv_ready;
    sb2d_pkg::t_conv_result      w_conv_result;
    logic [sb2d_pkg::CHAR_W-1:0] w_char;

    // Binary to BCD conversion, one bit per cycle.
    sb2d_dabble u_dabble (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_axis_tvalid),
        .o_ready  (o_s_axis_tready),
        .i_value  (i_s_axis_tdata),
        .o_valid  (w_conv_valid),
        .i_ready  (w_conv_ready),
        .o_result (w_conv_result)
    );

    // Sign and digit serializer with output register.
    sb2d_emit u_emit (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_conv_valid),
        .o_ready  (w_conv_ready),
        .i_result (w_conv_result),
        .o_tvalid (o_m_axis_tvalid),
        .i_tready (i_m_axis_tready),
        .o_char   (w_char),
        .o_last   (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {{(8 - sb2d_pkg::CHAR_W){1'b0}}, w_char};

endmodule
